// ===== hdl/dq_pkg.sv =====
`timescale 1ns / 1ps
package dq_pkg;

   // Ring size and the widths that follow from it.
   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Fixed field widths of the channels.
   localparam int CMD_W = 3;
   localparam int VAL_W = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 7;

   // Depth of the queue between the front and the back.
   localparam int OPQ_DEPTH = 2;
   localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

   // Command codes on the request channel.
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DROP_BACK = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_ALL = 3'd4;

   // Status codes on the response channel.
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] element;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0] occupancy;
      logic last;
   } rsp_type;

   // Classified operation handed from the front to the back.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_DROP_FRONT,
      OP_DROP_BACK,
      OP_READ_ALL,
      OP_NOP
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic signed [VAL_W-1:0] value;
   } op_type;

   // Ring position base + off, where off is below DEPTH.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/dq_front.sv =====
`timescale 1ns / 1ps
module dq_front
   import dq_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    opq_full,
   output logic    opq_push,
   output op_type  opq_data
);

   // Requests are taken whenever the operation queue has room.
   assign req_stall = opq_full;
   assign opq_push  = req_valid && !opq_full;

   always_comb begin
      opq_data.value = req_payload.value;
      unique case (req_payload.command)
         CMD_PUSH_FRONT: opq_data.code = OP_PUSH_FRONT;
         CMD_PUSH_BACK:  opq_data.code = OP_PUSH_BACK;
         CMD_DROP_FRONT: opq_data.code = OP_DROP_FRONT;
         CMD_DROP_BACK:  opq_data.code = OP_DROP_BACK;
         CMD_READ_ALL:   opq_data.code = OP_READ_ALL;
         default:        opq_data.code = OP_NOP;
      endcase
   end

endmodule

// ===== hdl/dq_op_fifo.sv =====
`timescale 1ns / 1ps
module dq_op_fifo
   import dq_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_data
);

   op_type                 slot_ff [OPQ_DEPTH];
   logic [OPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == OPQ_CNT_W'(OPQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/dq_back.sv =====
`timescale 1ns / 1ps
module dq_back
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op_data,
   output logic    op_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic               pend_last_ff, pend_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;

   logic               out_free;
   logic               is_full;
   logic               is_empty;
   logic               stream_last;
   logic [IDX_W-1:0]   front_dec;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign is_full     = (count_ff == CNT_W'(DEPTH));
   assign is_empty    = (count_ff == '0);
   assign stream_last = ((idx_ff + CNT_W'(1)) == count_ff);
   assign front_dec   = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign rd_addr     = ring_add(front_ff, idx_ff);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      op_pop       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = front_dec;
      rd_en        = 1'b0;

      // The element held in the read register moves to the output once it is free.
      if (pend_ff && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.element   = rd_data_ff;
         rsp_in.status    = STATUS_DONE;
         rsp_in.occupancy = OCC_W'(count_ff);
         rsp_in.last      = pend_last_ff;
         pend_in          = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && !pend_ff && out_free) begin
               op_pop           = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_in.element   = '0;
               rsp_in.status    = STATUS_DONE;
               rsp_in.occupancy = OCC_W'(count_ff);
               rsp_in.last      = 1'b1;
               unique case (op_data.code) inside
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = OCC_W'(count_ff + 1'b1);
                        if (op_data.code == OP_PUSH_FRONT) begin
                           front_in = front_dec;
                        end else begin
                           mem_waddr = ring_add(front_ff, count_ff);
                        end
                     end
                  end
                  OP_DROP_FRONT, OP_DROP_BACK: begin
                     if (is_empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        count_in         = count_ff - 1'b1;
                        rsp_in.occupancy = OCC_W'(count_ff - 1'b1);
                        if (op_data.code == OP_DROP_FRONT) begin
                           front_in = ring_add(front_ff, CNT_W'(1));
                        end
                     end
                  end
                  OP_READ_ALL: begin
                     if (is_empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = ST_STREAM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STREAM: begin
            // Issue the next read when the read stage is empty or draining.
            if (!pend_ff || out_free) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = stream_last;
               idx_in       = idx_ff + 1'b1;
               if (stream_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= op_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// The request channel (req_valid, req_stall, req_payload) carries one
// command and one value per transaction: push front, push back, drop front,
// drop back, or read out every element from front to back. The response
// channel (rsp_valid, rsp_stall, rsp_payload) returns one transaction per
// push, drop, unused command or empty read-out, and one per stored element
// for a read-out, with last set on the final response of each request.
// A push or drop response passes the operation queue and the response
// register; a read-out also passes the stream state and the read register.
// While rsp_stall is low, push and drop requests sustain one transaction per
// cycle, and a read-out streams one element per cycle from the single
// registered read port of the entry memory; the back end takes its next
// request only after the last element has left the read stage.
// Reset clears the front index, the element count and all handshake state;
// entry contents are left as they are, since only occupied entries are read.
// A stalled response holds its payload; the back end then stops, the
// two-entry operation queue fills, and req_stall rises.
module double_ended_queue_core
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // Decoded operations travel from the front end to the back end through
   // a short queue, so that request acceptance and execution stall apart.
   logic   opq_full;
   logic   opq_push;
   op_type opq_push_data;
   logic   opq_pop;
   logic   opq_head_valid;
   op_type opq_head_data;

   dq_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .opq_full    (opq_full),
      .opq_push    (opq_push),
      .opq_data    (opq_push_data)
   );

   dq_op_fifo u_op_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (opq_push),
      .push_data  (opq_push_data),
      .full       (opq_full),
      .pop        (opq_pop),
      .head_valid (opq_head_valid),
      .head_data  (opq_head_data)
   );

   // The back end owns the entry memory, the front index and the count.
   dq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (opq_head_valid),
      .op_data     (opq_head_data),
      .op_pop      (opq_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/dq_checker.sv =====
`timescale 1ns / 1ps
module dq_checker
   import dq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // No response may be offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered right after reset");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Empty and full status end a request and carry no element.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_payload.status != STATUS_DONE
                    |-> rsp_payload.last && rsp_payload.element == '0)
      else $error("flagged response is not a final, empty one");

   // A rejected push reports a full ring; an empty flag reports none stored.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_payload.status == STATUS_FULL
                    |-> rsp_payload.occupancy == OCC_W'(DEPTH))
      else $error("full status without full occupancy");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_payload.status == STATUS_EMPTY
                    |-> rsp_payload.occupancy == '0)
      else $error("empty status with stored elements");

endmodule

bind double_ended_queue_core dq_checker u_checker (.*);

// ===== dv/double_ended_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the double-ended queue core. The initial block below
// queues up request transactions phase by phase; a clocked driver presents
// them on the request channel, and a clocked monitor predicts the response
// transactions of every accepted request and checks every accepted response
// against the oldest prediction.
module double_ended_queue_core_tb;
   import dq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Requests waiting to be driven, and responses that the predictor says
   // are still to come, oldest first.
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   // Idle percentages of the two sides; changed between phases only.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;

   // Predictor state: its own copy of the ring, the front slot and the count.
   logic [VAL_W-1:0] ring_words[DEPTH];
   logic [IDX_W-1:0] head_index = '0;
   logic [CNT_W-1:0] fill_count = '0;

   double_ended_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // Ring slot that lies offset places behind the current front.
   function automatic logic [IDX_W-1:0] ring_slot(input int offset);
      return IDX_W'((int'(head_index) + offset) % DEPTH);
   endfunction

   function automatic rsp_type make_rsp(input logic [VAL_W-1:0] element,
                                        input logic [STATUS_W-1:0] status,
                                        input logic [CNT_W-1:0] occupancy,
                                        input logic last);
      rsp_type r;
      r.element = element;
      r.status = status;
      r.occupancy = OCC_W'(occupancy);
      r.last = last;
      return r;
   endfunction

   // Appends one predicted response at the tail of the expected list.
   task automatic queue_rsp(input rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // Updates the predictor for one accepted request and queues the responses
   // it must cause.
   task automatic predict_deque(input req_type r);
      int i;
      case (r.command)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (fill_count >= CNT_W'(DEPTH)) begin
               // A push onto a full queue is dropped and flagged.
               queue_rsp(make_rsp('0, STATUS_FULL, fill_count, 1'b1));
            end else begin
               if (r.command == CMD_PUSH_FRONT) begin
                  head_index = ring_slot(DEPTH - 1);
                  ring_words[head_index] = r.value;
               end else begin
                  ring_words[ring_slot(int'(fill_count))] = r.value;
               end
               fill_count = fill_count + 1'b1;
               queue_rsp(make_rsp('0, STATUS_DONE, fill_count, 1'b1));
            end
         end
         CMD_DROP_FRONT, CMD_DROP_BACK: begin
            if (fill_count == '0) begin
               queue_rsp(make_rsp('0, STATUS_EMPTY, '0, 1'b1));
            end else begin
               if (r.command == CMD_DROP_FRONT) begin
                  head_index = ring_slot(1);
               end
               fill_count = fill_count - 1'b1;
               queue_rsp(make_rsp('0, STATUS_DONE, fill_count, 1'b1));
            end
         end
         CMD_READ_ALL: begin
            if (fill_count == '0) begin
               queue_rsp(make_rsp('0, STATUS_EMPTY, '0, 1'b1));
            end else begin
               for (i = 0; i < int'(fill_count); i++) begin
                  queue_rsp(make_rsp(ring_words[ring_slot(i)], STATUS_DONE,
                                     fill_count, i + 1 == int'(fill_count)));
               end
            end
         end
         default: begin
            // Unused command codes leave the queue alone and report occupancy.
            queue_rsp(make_rsp('0, STATUS_DONE, fill_count, 1'b1));
         end
      endcase
   endtask

   // Driver. A new transaction is offered only when the previous one has been
   // taken (or none is up); while stalled, valid and payload hold. Valid never
   // looks at the stall of the current cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor. Both channels are sampled at the rising edge, before any of
   // this edge's updates land, so accepted transactions are seen exactly once.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_deque(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transaction: element %0d status %0d occupancy %0d",
                      rsp_payload.element, rsp_payload.status, rsp_payload.occupancy);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp_payload.element);
                  error_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  error_count++;
               end
               if (rsp_payload.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_payload.occupancy);
                  error_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_payload.last);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic add_req(input logic [CMD_W-1:0] command, input logic [VAL_W-1:0] value);
      req_type r;
      r.command = command;
      r.value = value;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // Mostly uniform words, with the extremes mixed in now and then.
   function automatic logic [VAL_W-1:0] pick_word();
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_side(input logic [CMD_W-1:0] front_cmd,
                                                  input logic [CMD_W-1:0] back_cmd);
      return $urandom_range(1) ? front_cmd : back_cmd;
   endfunction

   // Random traffic built from well-formed runs: bursts of pushes, bursts of
   // drops and read-outs, with a little noise that includes unused codes.
   task automatic add_random_traffic(input int target);
      int issued;
      int n;
      int k;
      int pick;
      issued = 0;
      while (issued < target) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            n = $urandom_range(24, 1);
            for (k = 0; k < n; k++) begin
               add_req(pick_side(CMD_PUSH_FRONT, CMD_PUSH_BACK), pick_word());
            end
         end else if (pick < 70) begin
            n = $urandom_range(12, 1);
            for (k = 0; k < n; k++) begin
               add_req(pick_side(CMD_DROP_FRONT, CMD_DROP_BACK), $urandom);
            end
         end else if (pick < 87) begin
            n = 1;
            add_req(CMD_READ_ALL, $urandom);
         end else begin
            n = $urandom_range(3, 1);
            for (k = 0; k < n; k++) begin
               add_req(CMD_W'($urandom_range(7)), $urandom);
            end
         end
         issued += n;
      end
   endtask

   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase zero, no idling on either side. Directed corner cases first:
      // every command against an empty queue, unused codes, extreme words.
      add_req(CMD_READ_ALL, 32'h1234_5678);
      add_req(CMD_DROP_FRONT, 32'hFFFF_FFFF);
      add_req(CMD_DROP_BACK, 32'h0000_0000);
      add_req(CMD_W'(5), 32'hDEAD_BEEF);
      add_req(CMD_W'(6), 32'h0000_0001);
      add_req(CMD_W'(7), 32'h8000_0000);
      add_req(CMD_PUSH_FRONT, 32'h8000_0000);
      add_req(CMD_PUSH_BACK, 32'h7FFF_FFFF);
      add_req(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      add_req(CMD_PUSH_BACK, 32'h0000_0000);
      add_req(CMD_READ_ALL, 32'h0000_0000);
      add_req(CMD_DROP_FRONT, 32'h0);
      add_req(CMD_DROP_BACK, 32'h0);
      add_req(CMD_READ_ALL, 32'hFFFF_FFFF);
      add_req(CMD_PUSH_BACK, 32'h5555_5555);
      add_req(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
      add_req(CMD_W'(7), 32'h7FFF_FFFF);
      add_req(CMD_READ_ALL, 32'h0);
      for (k = 0; k < 5; k++) begin
         add_req(pick_side(CMD_DROP_FRONT, CMD_DROP_BACK), 32'h0);
      end
      add_req(CMD_READ_ALL, 32'h0);

      // Fill to the brim, with pushes past full, a full read-out, a wrap of
      // the back end around the ring, then a drain past empty.
      for (k = 0; k < DEPTH + 2; k++) begin
         add_req(pick_side(CMD_PUSH_FRONT, CMD_PUSH_BACK), pick_word());
      end
      add_req(CMD_READ_ALL, 32'h0);
      add_req(CMD_DROP_FRONT, 32'h0);
      add_req(CMD_PUSH_BACK, pick_word());
      add_req(CMD_PUSH_FRONT, pick_word());
      add_req(CMD_READ_ALL, 32'h0);
      for (k = 0; k < DEPTH + 2; k++) begin
         add_req(pick_side(CMD_DROP_FRONT, CMD_DROP_BACK), $urandom);
      end
      add_req(CMD_READ_ALL, 32'h0);
      wait_quiet();

      // Sender idles, receiver always ready.
      send_idle_pct = 47;
      recv_stall_pct = 0;
      add_random_traffic(15);
      wait_quiet();

      // Sender always ready, receiver stalls.
      send_idle_pct = 0;
      recv_stall_pct = 47;
      add_random_traffic(15);
      wait_quiet();

      // Both sides idle part of the time.
      send_idle_pct = 27;
      recv_stall_pct = 27;
      add_random_traffic(15);
      wait_quiet();

      // Let the pipeline run dry so any stray response shows up.
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("double_ended_queue_core_tb OK");
      end else begin
         $display("double_ended_queue_core_tb NOT OK");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #2_000_000;
      $display("double_ended_queue_core_tb NOT OK");
      $finish;
   end

endmodule
